// ----- rtl/lsd_pkg.sv -----
// ----------------------------------------------------------------------------
// lsd_pkg
// shared types and constants of the lsb deframer: phase codes, result kinds,
// field widths and the filename header size
// ----------------------------------------------------------------------------
package lsd_pkg;

   localparam int SUBPIXEL_W = 8;
   localparam int KIND_W     = 2;
   localparam int VALUE_W    = 32;
   localparam int HDR_CNT_W  = 12;
   localparam int BIT_IDX_W  = 3;
   localparam int BYTE_W     = 8;

   // size of the filename header in bits
   localparam int NAME_BITS  = 2048;

   localparam logic [KIND_W-1:0] KIND_LENGTH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NAME   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_NAME = 2'd1,
      PH_DATA = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef struct packed {
      logic                valid;
      logic [KIND_W-1:0]   kind;
      logic [VALUE_W-1:0]  value;
      logic                last;
   } rsl_type;

endpackage

// ----- rtl/lsd_extract.sv -----
// ----------------------------------------------------------------------------
// lsd_extract
// bit collector and phase sequencer: takes one lsb per step and decides
// whether the step yields a length, a filename character or a payload byte
// ----------------------------------------------------------------------------
module lsd_extract
   import lsd_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    lsb,
   output rsl_type rsl
);

   localparam logic [HDR_CNT_W:0] LEN_LIMIT  = (HDR_CNT_W+1)'(LENGTH_BITS);
   localparam logic [HDR_CNT_W:0] NAME_LIMIT = (HDR_CNT_W+1)'(NAME_BITS);

   phase_type                phase_ff, phase_in;
   logic [HDR_CNT_W-1:0]     hdr_cnt_ff, hdr_cnt_in;
   logic [BIT_IDX_W-1:0]     bit_idx_ff, bit_idx_in;
   logic [LENGTH_BITS-1:0]   collect_ff, collect_in;
   logic [LENGTH_BITS-1:0]   length_ff, length_in;
   logic [LENGTH_BITS-1:0]   bytes_ff, bytes_in;

   logic [LENGTH_BITS-1:0]   shift_next;
   logic [HDR_CNT_W-1:0]     hdr_inc;
   logic [BIT_IDX_W-1:0]     bit_inc;
   logic [LENGTH_BITS-1:0]   bytes_inc;
   logic [BYTE_W-1:0]        cur_byte;
   logic                     len_done;
   logic                     name_done;
   logic                     byte_done;
   logic                     is_last;

   assign shift_next = {collect_ff[LENGTH_BITS-2:0], lsb};
   assign hdr_inc    = hdr_cnt_ff + 1'b1;
   assign bit_inc    = bit_idx_ff + 1'b1;
   assign bytes_inc  = bytes_ff + 1'b1;
   assign cur_byte   = shift_next[BYTE_W-1:0];
   assign len_done   = {1'b0, hdr_inc} >= LEN_LIMIT;
   assign name_done  = {1'b0, hdr_inc} >= NAME_LIMIT;
   assign byte_done  = (bit_inc == '0);
   assign is_last    = (bytes_inc == length_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (len_done) phase_in = PH_NAME;
            end
            PH_NAME: begin
               if (name_done) phase_in = (length_ff != '0) ? PH_DATA : PH_DONE;
            end
            PH_DATA: begin
               if (byte_done && is_last) phase_in = PH_DONE;
            end
            PH_DONE: phase_in = PH_DONE;
            default: phase_in = PH_LEN;
         endcase
      end
   end

   // datapath updates and result
   always_comb begin
      hdr_cnt_in = hdr_cnt_ff;
      bit_idx_in = bit_idx_ff;
      collect_in = collect_ff;
      length_in  = length_ff;
      bytes_in   = bytes_ff;
      rsl        = '0;
      if (step) begin
         unique case (phase_ff)
            PH_LEN: begin
               collect_in = shift_next;
               hdr_cnt_in = hdr_inc;
               if (len_done) begin
                  length_in  = shift_next;
                  rsl.valid  = 1'b1;
                  rsl.kind   = KIND_LENGTH;
                  rsl.value  = VALUE_W'(shift_next);
                  hdr_cnt_in = '0;
                  bit_idx_in = '0;
                  collect_in = '0;
               end
            end
            PH_NAME: begin
               collect_in = shift_next;
               bit_idx_in = bit_inc;
               hdr_cnt_in = hdr_inc;
               if (byte_done) begin
                  collect_in = '0;
                  if (cur_byte != '0) begin
                     rsl.valid = 1'b1;
                     rsl.kind  = KIND_NAME;
                     rsl.value = VALUE_W'(cur_byte);
                  end
               end
               if (name_done) begin
                  hdr_cnt_in = '0;
                  bit_idx_in = '0;
                  collect_in = '0;
                  bytes_in   = '0;
               end
            end
            PH_DATA: begin
               collect_in = shift_next;
               bit_idx_in = bit_inc;
               if (byte_done) begin
                  collect_in = '0;
                  bytes_in   = bytes_inc;
                  rsl.valid  = 1'b1;
                  rsl.kind   = KIND_DATA;
                  rsl.value  = VALUE_W'(cur_byte);
                  rsl.last   = is_last;
               end
            end
            PH_DONE: begin
               rsl = '0;
            end
            default: begin
               rsl = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEN;
         hdr_cnt_ff <= '0;
         bit_idx_ff <= '0;
         collect_ff <= '0;
         length_ff  <= '0;
         bytes_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         bit_idx_ff <= bit_idx_in;
         collect_ff <= collect_in;
         length_ff  <= length_in;
         bytes_ff   <= bytes_in;
      end
   end

endmodule

// ----- rtl/lsd_rsp_reg.sv -----
// ----------------------------------------------------------------------------
// lsd_rsp_reg
// result register: holds one result item while the receiver stalls
// ----------------------------------------------------------------------------
module lsd_rsp_reg
   import lsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rsl_type             rsl,
   input  logic                rsp_stall,
   output logic                free,
   output logic                rsp_valid,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic                rsp_last
);

   logic                valid_ff, valid_in;
   logic [KIND_W-1:0]   kind_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic                last_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = free ? rsl.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && rsl.valid) begin
         kind_ff  <= rsl.kind;
         value_ff <= rsl.value;
         last_ff  <= rsl.last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_value = value_ff;
   assign rsp_last  = last_ff;

endmodule

// ----- rtl/lsb_stego_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// lsb_stego_deframer_unit
// least significant bit deframer for image subpixel streams
// ----------------------------------------------------------------------------
// Each accepted subpixel item contributes its bit 0, gathered msb first. The
// first LENGTH_BITS bits give the unsigned payload length (one result of kind
// length), the next 2048 bits give filename characters (one result per
// non-zero character), then payload bytes follow until the length is reached,
// the final one flagged last. After that every subpixel is swallowed until
// reset. One item is taken every clock cycle while the result side does not
// stall; an item passes an input register and then a result register before
// its result shows. A stalled result holds the pipe, and the input register
// holds one more item behind it.
module lsb_stego_deframer_unit
   import lsd_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SUBPIXEL_W-1:0] req_subpixel,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [VALUE_W-1:0]    rsp_value,
   output logic                  rsp_last
);

   // input register: only the lsb of the subpixel is kept
   logic    in_valid_ff, in_valid_in;
   logic    in_bit_ff;
   logic    rsp_free;
   logic    accept;
   logic    step;
   rsl_type rsl;

   // the input stage moves on whenever the result register can take a result
   assign step      = in_valid_ff && rsp_free;
   assign req_stall = in_valid_ff && !rsp_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_bit_ff <= req_subpixel[0];
      end
   end

   // bit collection and phase sequencing
   lsd_extract #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_extract (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .lsb   (in_bit_ff),
      .rsl   (rsl)
   );

   // result register toward the receiver
   lsd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .rsl       (rsl),
      .rsp_stall (rsp_stall),
      .free      (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_kind  (rsp_kind),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_last)
   );

endmodule

// ----- rtl/lsd_checker.sv -----
// ----------------------------------------------------------------------------
// lsd_checker
// port level checks of the deframer's result items
// ----------------------------------------------------------------------------
module lsd_checker
   import lsd_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [KIND_W-1:0]     rsp_kind,
   input logic [VALUE_W-1:0]    rsp_value,
   input logic                  rsp_last
);

   logic [VALUE_W-1:0] len_span;
   assign len_span = (LENGTH_BITS >= VALUE_W) ? '0 : (rsp_value >> LENGTH_BITS);

   // only the three result kinds appear
   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_LENGTH || rsp_kind == KIND_NAME ||
                     rsp_kind == KIND_DATA))
      else $error("unknown result kind");

   // last flag only on payload bytes
   a_last_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_DATA)
      else $error("last on a non-payload item");

   // character and byte results fit in eight bits, characters never zero
   a_byte_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_LENGTH |->
         rsp_value[VALUE_W-1:BYTE_W] == '0 &&
         (rsp_kind != KIND_NAME || rsp_value[BYTE_W-1:0] != '0))
      else $error("byte result out of range");

   // length result fits the header width
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_LENGTH |-> len_span == '0)
      else $error("length wider than header");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) &&
         $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind lsb_stego_deframer_unit lsd_checker #(
   .LENGTH_BITS (LENGTH_BITS)
) u_lsd_checker (.*);

// ----- tb/tb_lsb_stego_deframer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lsb_stego_deframer_unit
// self-checking bench for the lsb deframer: one frame of length header,
// filename header and payload, then trailing subpixels that must be dropped
// ----------------------------------------------------------------------------
// The bench tracks the deframer state itself and works out, for each accepted
// subpixel item, the result that should come out. Results are compared field
// by field in order. Since reset is applied only once, every run carries one
// frame: the payload length is drawn per seed, zero length among the choices,
// so the empty payload and the multi-byte payload paths are reached across seeds.
// Both handshake sides idle at random, with calm stretches in between.
module tb_lsb_stego_deframer_unit;
   import lsd_pkg::*;

   localparam int LEN_BITS     = 32;
   localparam int NAME_CHARS   = NAME_BITS / BYTE_W;
   localparam int PIPE_DRAIN   = 40;
   localparam int RUN_LIMIT_NS = 2_000_000;
   localparam int TAIL_ITEMS   = 48;

   // expected fields of one result
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic               last;
   } extract_type;

   // one row of the opening sequence; quiet rows have "no result" typed in
   typedef struct packed {
      logic [SUBPIXEL_W-1:0] subpixel;
      logic                  quiet;
   } opening_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [SUBPIXEL_W-1:0] req_subpixel;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [KIND_W-1:0]     rsp_kind;
   logic [VALUE_W-1:0]    rsp_value;
   logic                  rsp_last;

   // results still to come, oldest first
   extract_type extracted_q [$];
   int          mismatches = 0;
   int          sent_items = 0;
   bit          snd_calm   = 1'b0;

   // tracked deframer state
   phase_type              trk_phase    = PH_LEN;
   logic [HDR_CNT_W-1:0]   trk_hdr_bits = '0;
   logic [BIT_IDX_W-1:0]   trk_bit_idx  = '0;
   logic [VALUE_W-1:0]     trk_shift    = '0;
   logic [VALUE_W-1:0]     trk_length   = '0;
   logic [VALUE_W-1:0]     trk_bytes    = '0;

   // first 24 length bits: all bit 0 clear, upper bits walked over both values
   // so the drawn low byte alone sets the payload length
   localparam opening_row_type OPENING [24] = '{
      '{8'h00, 1'b1}, '{8'hFE, 1'b1}, '{8'h02, 1'b1}, '{8'h80, 1'b1},
      '{8'h7E, 1'b1}, '{8'h40, 1'b1}, '{8'h20, 1'b1}, '{8'h10, 1'b1},
      '{8'h08, 1'b1}, '{8'h04, 1'b1}, '{8'hAA, 1'b1}, '{8'h54, 1'b1},
      '{8'hF0, 1'b1}, '{8'h0E, 1'b1}, '{8'hC2, 1'b1}, '{8'h3C, 1'b1},
      '{8'h66, 1'b1}, '{8'h98, 1'b1}, '{8'hDE, 1'b1}, '{8'hB4, 1'b1},
      '{8'h6A, 1'b1}, '{8'h12, 1'b1}, '{8'hE8, 1'b1}, '{8'h2C, 1'b1}
   };

   lsb_stego_deframer_unit #(
      .LENGTH_BITS (LEN_BITS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_subpixel (req_subpixel),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // idle cycles before the next item; none in calm stretches
   function automatic int draw_idle(input bit calm);
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   // take bit 0 of one subpixel and advance the tracked state
   function automatic void extract_lsb(input logic [SUBPIXEL_W-1:0] sp,
                                       output logic got, output extract_type res);
      logic [63:0] len_mask;
      got = 1'b0;
      res = '0;
      len_mask = (64'd1 << LEN_BITS) - 64'd1;
      case (trk_phase)
         PH_LEN: begin
            trk_shift    = {trk_shift[VALUE_W-2:0], sp[0]};
            trk_hdr_bits = trk_hdr_bits + 1'b1;
            if (trk_hdr_bits >= LEN_BITS) begin
               trk_length   = trk_shift & len_mask[VALUE_W-1:0];
               got          = 1'b1;
               res          = '{KIND_LENGTH, trk_length, 1'b0};
               trk_hdr_bits = '0;
               trk_bit_idx  = '0;
               trk_shift    = '0;
               trk_phase    = PH_NAME;
            end
         end
         PH_NAME: begin
            trk_shift    = {trk_shift[VALUE_W-2:0], sp[0]};
            trk_bit_idx  = trk_bit_idx + 1'b1;
            trk_hdr_bits = trk_hdr_bits + 1'b1;
            if (trk_bit_idx == '0) begin
               // zero characters are padding and give nothing
               if (trk_shift[BYTE_W-1:0] != '0) begin
                  got = 1'b1;
                  res = '{KIND_NAME, VALUE_W'(trk_shift[BYTE_W-1:0]), 1'b0};
               end
               trk_shift = '0;
            end
            if (trk_hdr_bits >= NAME_BITS) begin
               trk_hdr_bits = '0;
               trk_bit_idx  = '0;
               trk_shift    = '0;
               trk_bytes    = '0;
               // empty payload skips straight to the end
               trk_phase    = (trk_length != '0) ? PH_DATA : PH_DONE;
            end
         end
         PH_DATA: begin
            trk_shift   = {trk_shift[VALUE_W-2:0], sp[0]};
            trk_bit_idx = trk_bit_idx + 1'b1;
            if (trk_bit_idx == '0) begin
               trk_bytes = trk_bytes + 1'b1;
               got       = 1'b1;
               res       = '{KIND_DATA, VALUE_W'(trk_shift[BYTE_W-1:0]),
                             trk_bytes == trk_length};
               trk_shift = '0;
               if (trk_bytes == trk_length) trk_phase = PH_DONE;
            end
         end
         default: ; // done: everything is dropped until reset
      endcase
   endfunction

   // hand one subpixel over, then record what it should produce
   task automatic send_subpixel(input logic [SUBPIXEL_W-1:0] sp, input logic quiet);
      int          gap;
      logic        got;
      extract_type res;
      if (sent_items % 64 == 0) snd_calm = ($urandom_range(0, 3) == 0);
      gap = draw_idle(snd_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_subpixel <= sp;
      do @(posedge clock); while (req_stall);
      extract_lsb(sp, got, res);
      // quiet rows carry "no result" as their typed expectation
      if (got && !quiet) extracted_q.push_back(res);
      sent_items++;
   endtask

   // hide one byte, msb first, in bit 0 of eight random subpixels
   task automatic send_byte(input logic [BYTE_W-1:0] data);
      logic [SUBPIXEL_W-1:0] noise;
      for (int b = BYTE_W - 1; b >= 0; b--) begin
         noise = SUBPIXEL_W'($urandom_range(0, 255));
         send_subpixel({noise[SUBPIXEL_W-1:1], data[b]}, 1'b0);
      end
   endtask

   // sender holds off until every pending result has been taken
   task automatic wait_results_out();
      req_valid <= 1'b0;
      do @(posedge clock); while (extracted_q.size() != 0);
   endtask

   // result side: random stalls per result, compare in order
   initial begin : result_sink
      int          stall_n;
      int          taken;
      bit          rcv_calm;
      extract_type want;
      rsp_stall = 1'b0;
      taken     = 0;
      rcv_calm  = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 32 == 0) rcv_calm = ($urandom_range(0, 3) == 0);
         stall_n = draw_idle(rcv_calm);
         if (stall_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         if (extracted_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d value %0h last %0b",
                                      rsp_kind, rsp_value, rsp_last));
         end else begin
            want = extracted_q.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, wanted %0d", rsp_kind, want.kind));
            if (rsp_value !== want.value)
               report_mismatch($sformatf("value %0h, wanted %0h", rsp_value, want.value));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, wanted %0b", rsp_last, want.last));
         end
      end
   end

   initial begin : stimulus
      int                pick;
      int                name_len;
      logic [BYTE_W-1:0] pay_len;
      logic [BYTE_W-1:0] ch;
      logic [SUBPIXEL_W-1:0] noise;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_subpixel = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // opening: upper length bits, right after reset
      foreach (OPENING[i]) send_subpixel(OPENING[i].subpixel, OPENING[i].quiet);

      // payload length for this frame; empty and single byte payloads weighted up
      pick = $urandom_range(0, 7);
      if (pick < 2)       pay_len = '0;
      else if (pick == 2) pay_len = 8'd1;
      else                pay_len = BYTE_W'($urandom_range(2, 40));
      send_byte(pay_len);

      // pause with the length result in flight
      wait_results_out();

      // filename: a short name padded with zero characters, stray bytes in the
      // padding and now and then a zero inside the name; sometimes full width
      name_len = ($urandom_range(0, 7) == 0) ? NAME_CHARS : $urandom_range(1, 40);
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (i == 0)
            ch = 8'hFF;
         else if (i == 1)
            ch = 8'h01;
         else if (i < name_len)
            ch = ($urandom_range(0, 15) == 0) ? 8'h00 : BYTE_W'($urandom_range(1, 255));
         else
            ch = ($urandom_range(0, 31) == 0) ? BYTE_W'($urandom_range(1, 255)) : 8'h00;
         send_byte(ch);
         if (i == NAME_CHARS / 2) wait_results_out();
      end

      // payload bytes, last one flagged
      for (int i = 0; i < int'(pay_len); i++) send_byte(BYTE_W'($urandom_range(0, 255)));

      // after the frame every subpixel must be swallowed
      for (int i = 0; i < TAIL_ITEMS; i++) begin
         noise = SUBPIXEL_W'($urandom_range(0, 255));
         send_subpixel(noise, 1'b0);
      end
      req_valid <= 1'b0;

      // wait for every expected result, then watch for strays
      while (extracted_q.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
